// File: src/gvwm_pkg.sv
// Package for the grid vertex weld map: opcodes, status codes, hash constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gvwm_pkg;
  localparam int MaxVertsDefault   = 1024;
  localparam int TableSlotsDefault = 1024;
  localparam logic [31:0] FnvBasis = 32'd2166136261;
  localparam logic [31:0] FnvPrime = 32'd16777619;
  localparam logic [31:0] InvTolReset = 32'd65536;

  localparam logic [1:0] OpClear  = 2'd0;
  localparam logic [1:0] OpWeld   = 2'd1;
  localparam logic [1:0] OpRemap  = 2'd2;
  localparam logic [1:0] OpUnused = 2'd3;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StCapacity = 2'd1;
  localparam logic [1:0] StUnwelded = 2'd2;

  // request into the shared multiplier
  typedef struct packed {
    logic        start;
    logic [31:0] a;
    logic [31:0] b;
  } mul_req_t;
endpackage
`default_nettype wire

// File: src/gvwm_mul.sv
// Shared registered 32x32 unsigned multiplier for the weld map sequencer.
// Depends on gvwm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gvwm_mul (
  input  wire logic             clk,
  input  wire gvwm_pkg::mul_req_t req,
  output logic [63:0]           product
);
  always_ff @(posedge clk) begin
    if (req.start) begin
      product <= {32'd0, req.a} * {32'd0, req.b};
    end
  end
endmodule
`default_nettype wire

// File: src/grid_vertex_weld_map.sv
// Grid vertex weld map: floors positions to a grid, hashes cells with FNV-1a,
// probes an open-addressed table linearly and assigns canonical ids.
// A weld floors each axis, hashes, reduces modulo TABLE_SLOTS, then reads and
// compares one slot per probe step; remap reads the weld map; rejected or
// unwelded items go straight out; clear drops one slot valid bit per cycle.
// One item at a time; the shared multiplier and the single table read port
// set the rate. Sync rst clears counts and the table, not ready meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module grid_vertex_weld_map #(
  parameter int MAX_VERTS   = gvwm_pkg::MaxVertsDefault,
  parameter int TABLE_SLOTS = gvwm_pkg::TableSlotsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // opcode[1:0], pos_x[33:2], pos_y[65:34], pos_z[97:66], vertex_index[107:98]
  input  wire logic [111:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // canonical_id[9:0], is_new[10], canonical_count[21:11],
  // vertex_count[32:22], status[34:33]
  output logic [39:0]      m_tdata
);
  localparam int SW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int VW = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
  localparam int CW = $clog2(MAX_VERTS + 1);
  localparam int SC = $clog2(TABLE_SLOTS + 1);
  // floor(2^32 / TABLE_SLOTS): quotient estimate is exact or one low
  localparam logic [31:0] ModRecip = 32'((64'd1 << 32) / TABLE_SLOTS);

  localparam logic [3:0] S_IDLE = 4'd0, S_MUL = 4'd1, S_CELL = 4'd2,
    S_HASH = 4'd3, S_HMUL = 4'd4, S_MOD = 4'd5, S_READ = 4'd6,
    S_CMP = 4'd7, S_REMAP = 4'd8, S_RDONE = 4'd9, S_OUT = 4'd10,
    S_MQ = 4'd11, S_MR = 4'd12, S_CLR = 4'd13;

  logic [3:0]  state;
  logic [31:0] inv_tol;
  logic [31:0] pos [3];
  logic [VW-1:0] vidx_in;
  logic [1:0]  axis;
  logic [31:0] gcell [3];
  logic [31:0] hash;
  logic [SW-1:0] probe;
  logic [SC-1:0] probe_n;
  logic [SW-1:0] clr_addr;
  logic        clr_reply;
  logic [CW-1:0] next_id, welded;
  logic        slot_used [TABLE_SLOTS];
  logic [95:0] slot_cell [TABLE_SLOTS];
  logic [9:0]  slot_id_mem [TABLE_SLOTS];
  logic [9:0]  weld_map [MAX_VERTS];
  logic [95:0] rd_cell;
  logic [9:0]  rd_id, rd_map;
  logic        rd_valid;
  logic [9:0]  res_id;
  logic        res_new;
  logic [1:0]  res_st;

  gvwm_pkg::mul_req_t mreq;
  logic [63:0] prod;
  gvwm_mul u_mul (.clk(clk), .req(mreq), .product(prod));

  logic [31:0] cur, mag;
  logic        neg;
  assign cur = pos[axis];
  assign neg = cur[31];
  assign mag = neg ? (~cur + 32'd1) : cur;

  // multiplier operands per sequencer step
  always_comb begin
    mreq.start = 1'b0;
    mreq.a = mag;
    mreq.b = inv_tol;
    if (state == S_MUL) mreq.start = 1'b1;
    if (state == S_HASH) begin
      mreq.start = 1'b1;
      mreq.a = hash ^ gcell[axis];
      mreq.b = gvwm_pkg::FnvPrime;
    end
    if (state == S_MOD) begin
      mreq.start = 1'b1;
      mreq.a = hash;
      mreq.b = ModRecip;
    end
    if (state == S_MQ) begin
      mreq.start = 1'b1;
      mreq.a = prod[63:32];
      mreq.b = 32'(TABLE_SLOTS);
    end
  end

  logic [31:0] floor_cell;
  assign floor_cell = neg ? (32'd0 - (prod[63:32] + {31'd0, |prod[31:0]}))
                          : prod[63:32];

  // hash minus estimated quotient times slots, below 2 * TABLE_SLOTS
  logic [31:0] rem;
  assign rem = hash - prod[31:0];

  assign s_tready  = (state == S_IDLE) && !rst;
  assign cfg_ready = (state == S_IDLE) && !rst;
  assign m_tvalid  = (state == S_OUT);
  assign m_tdata = {5'd0, res_st, 11'(welded), 11'(next_id), res_new, res_id};

  logic hit;
  assign hit = (rd_cell == {gcell[2], gcell[1], gcell[0]});

  // table read port, registered
  always_ff @(posedge clk) begin
    rd_cell <= slot_cell[probe];
    rd_id   <= slot_id_mem[probe];
    rd_valid <= slot_used[probe];
    rd_map  <= weld_map[vidx_in];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_addr <= '0;
      clr_reply <= 1'b0;
      inv_tol <= gvwm_pkg::InvTolReset;
      next_id <= '0;
      welded <= '0;
    end else begin
      if (cfg_valid && cfg_ready) inv_tol <= cfg_data;
      case (state)
        S_IDLE: if (s_tvalid) begin
          pos[0] <= s_tdata[33:2];
          pos[1] <= s_tdata[65:34];
          pos[2] <= s_tdata[97:66];
          vidx_in <= VW'(s_tdata[107:98]);
          axis <= 2'd0;
          res_id <= '0; res_new <= 1'b0; res_st <= gvwm_pkg::StOk;
          if (s_tdata[1:0] == gvwm_pkg::OpClear) begin
            next_id <= '0; welded <= '0;
            clr_addr <= '0; clr_reply <= 1'b1;
            state <= S_CLR;
          end else if (s_tdata[1:0] == gvwm_pkg::OpRemap) begin
            if ({1'b0, s_tdata[107:98]} < 11'(welded) &&
                32'(s_tdata[107:98]) < 32'(MAX_VERTS))
              state <= S_REMAP;
            else begin
              res_st <= gvwm_pkg::StUnwelded;
              state <= S_OUT;
            end
          end else if (s_tdata[1:0] == gvwm_pkg::OpWeld) begin
            if (32'(welded) >= 32'(MAX_VERTS)) begin
              res_st <= gvwm_pkg::StCapacity;
              state <= S_OUT;
            end else state <= S_MUL;
          end
        end
        // one slot valid bit per cycle; reply only for a clear item
        S_CLR: begin
          slot_used[clr_addr] <= 1'b0;
          if (32'(clr_addr) == 32'(TABLE_SLOTS - 1))
            state <= clr_reply ? S_OUT : S_IDLE;
          else clr_addr <= clr_addr + 1'b1;
        end
        S_MUL: state <= S_CELL;
        S_CELL: begin
          gcell[axis] <= floor_cell;
          if (axis == 2'd2) begin
            axis <= 2'd0; hash <= gvwm_pkg::FnvBasis; state <= S_HASH;
          end else begin
            axis <= axis + 2'd1; state <= S_MUL;
          end
        end
        S_HASH: state <= S_HMUL;
        S_HMUL: begin
          hash <= prod[31:0];
          if (axis == 2'd2) state <= S_MOD;
          else begin axis <= axis + 2'd1; state <= S_HASH; end
        end
        S_MOD: state <= S_MQ;
        S_MQ: state <= S_MR;
        S_MR: begin
          probe <= SW'((rem >= 32'(TABLE_SLOTS)) ? rem - 32'(TABLE_SLOTS) : rem);
          probe_n <= '0;
          state <= S_READ;
        end
        S_READ: state <= S_CMP;
        S_CMP: begin
          if (!rd_valid) begin
            slot_used[probe] <= 1'b1;
            slot_cell[probe] <= {gcell[2], gcell[1], gcell[0]};
            slot_id_mem[probe] <= 10'(next_id);
            weld_map[welded[VW-1:0]] <= 10'(next_id);
            res_id <= 10'(next_id); res_new <= 1'b1;
            next_id <= next_id + 1'b1; welded <= welded + 1'b1;
            state <= S_OUT;
          end else if (hit) begin
            weld_map[welded[VW-1:0]] <= rd_id;
            res_id <= rd_id;
            welded <= welded + 1'b1;
            state <= S_OUT;
          end else if (32'(probe_n) + 32'd1 >= 32'(TABLE_SLOTS)) begin
            res_st <= gvwm_pkg::StCapacity;
            state <= S_OUT;
          end else begin
            probe_n <= probe_n + 1'b1;
            probe <= (32'(probe) == 32'(TABLE_SLOTS - 1)) ? '0 : probe + 1'b1;
            state <= S_READ;
          end
        end
        S_REMAP: state <= S_RDONE;
        S_RDONE: begin res_id <= rd_map; state <= S_OUT; end
        S_OUT: if (m_tready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !s_tready) else $error("ready while busy");
  a_count: assert property (@(posedge clk) disable iff (rst)
    next_id <= welded) else $error("ids exceed welds");
  a_new: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res_new) |-> (res_st == gvwm_pkg::StOk)) else $error("bad new");
`endif
endmodule
`default_nettype wire

// File: dv/tb_grid_vertex_weld_map.sv
// Testbench for grid_vertex_weld_map: clear, weld and remap items with a built-in
// predictor of the grid hash table. Depends on src/gvwm_pkg.sv and the block RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb_grid_vertex_weld_map;

  localparam int Slots = 1024;
  localparam int Verts = 1024;
  localparam int WatchLimit = 20000;

  // packed from the highest bit down as on m_tdata
  typedef struct packed {
    logic [1:0]  st;
    logic [10:0] nvert;
    logic [10:0] ncanon;
    logic        fresh;
    logic [9:0]  cid;
  } weld_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [111:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [39:0] m_tdata;

  grid_vertex_weld_map dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // predictor state
  logic [31:0] inv_tol;
  bit          tbl_used [Slots];
  logic [31:0] tbl_cx [Slots];
  logic [31:0] tbl_cy [Slots];
  logic [31:0] tbl_cz [Slots];
  logic [9:0]  tbl_id [Slots];
  logic [9:0]  vmap [Verts];
  int unsigned ids_given;
  int unsigned verts_welded;

  weld_res_t expected_q[$];
  int errors = 0;
  int checked = 0;
  int idle_pct_src = 0;
  int idle_pct_snk = 0;
  int quiet_cycles = 0;
  int n_weld = 0, n_remap = 0, n_clear = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("MISMATCH %s: got %0h want %0h (result %0d)", what, got, want, checked);
  endtask

  // floor(coord * inv / 2^32), exact product in 64 bits
  function automatic logic [31:0] grid_cell(input logic [31:0] c, input logic [31:0] inv);
    logic signed [64:0] p;
    p = $signed({{33{c[31]}}, c}) * $signed({33'd0, inv});
    return p[63:32];
  endfunction

  function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [31:0] v);
    return (h ^ v) * gvwm_pkg::FnvPrime;
  endfunction

  function automatic weld_res_t mk_res(input logic [9:0] id, input logic f,
                                       input logic [1:0] st);
    weld_res_t r;
    r.cid = id; r.fresh = f; r.ncanon = ids_given[10:0]; r.nvert = verts_welded[10:0];
    r.st = st;
    return r;
  endfunction

  function automatic weld_res_t predict_weld_result(input logic [1:0] op, input logic [31:0] px,
      input logic [31:0] py, input logic [31:0] pz, input logic [9:0] vidx);
    logic [31:0] cx, cy, cz, h;
    int unsigned pos;
    logic [9:0] id;
    if (op == gvwm_pkg::OpClear) begin
      foreach (tbl_used[i]) tbl_used[i] = 0;
      ids_given = 0; verts_welded = 0;
      return mk_res(10'd0, 1'b0, gvwm_pkg::StOk);
    end
    if (op == gvwm_pkg::OpRemap) begin
      if (vidx < verts_welded) return mk_res(vmap[vidx], 1'b0, gvwm_pkg::StOk);
      return mk_res(10'd0, 1'b0, gvwm_pkg::StUnwelded);
    end
    if (verts_welded >= Verts) return mk_res(10'd0, 1'b0, gvwm_pkg::StCapacity);
    cx = grid_cell(px, inv_tol); cy = grid_cell(py, inv_tol); cz = grid_cell(pz, inv_tol);
    h = fnv_step(fnv_step(fnv_step(gvwm_pkg::FnvBasis, cx), cy), cz);
    pos = h % Slots;
    for (int n = 0; n < Slots; n++) begin
      if (!tbl_used[pos]) begin
        id = ids_given[9:0];
        tbl_used[pos] = 1; tbl_cx[pos] = cx; tbl_cy[pos] = cy; tbl_cz[pos] = cz;
        tbl_id[pos] = id;
        ids_given++;
        vmap[verts_welded] = id; verts_welded++;
        return mk_res(id, 1'b1, gvwm_pkg::StOk);
      end
      if (tbl_cx[pos] == cx && tbl_cy[pos] == cy && tbl_cz[pos] == cz) begin
        id = tbl_id[pos];
        vmap[verts_welded] = id; verts_welded++;
        return mk_res(id, 1'b0, gvwm_pkg::StOk);
      end
      pos = (pos + 1) % Slots;
    end
    return mk_res(10'd0, 1'b0, gvwm_pkg::StCapacity);
  endfunction

  // result checker and receiver stalls
  always @(posedge clk) begin
    weld_res_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[34:0];
        checked++;
        if (expected_q.size() == 0) begin
          report("unexpected result", m_tdata[31:0], 32'd0);
        end else begin
          want = expected_q.pop_front();
          if (got.cid !== want.cid) report("canonical_id", 32'(got.cid), 32'(want.cid));
          if (got.fresh !== want.fresh) report("is_new", 32'(got.fresh), 32'(want.fresh));
          if (got.ncanon !== want.ncanon)
            report("canonical_count", 32'(got.ncanon), 32'(want.ncanon));
          if (got.nvert !== want.nvert)
            report("vertex_count", 32'(got.nvert), 32'(want.nvert));
          if (got.st !== want.st) report("status", 32'(got.st), 32'(want.st));
        end
      end
      m_tready <= ($urandom_range(99) >= idle_pct_snk);
    end
  end

  // watchdog: cycles with nothing accepted anywhere
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else if (!rst)
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("watchdog expired with %0d results outstanding", expected_q.size());
      $display("tb_grid_vertex_weld_map: done, errors");
      $finish;
    end
  end

  // sends one item; the unused opcode is ignored by the block and expects nothing.
  // tvalid stays high after the accept so items can follow back to back.
  task automatic send_item(input logic [1:0] op, input logic [31:0] px, input logic [31:0] py,
                           input logic [31:0] pz, input logic [9:0] vidx);
    weld_res_t r;
    while ($urandom_range(99) < idle_pct_src) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata <= {4'd0, vidx, pz, py, px, op};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    if (op != gvwm_pkg::OpUnused) begin
      r = predict_weld_result(op, px, py, pz, vidx);
      expected_q.insert(expected_q.size(), r);
      if (op == gvwm_pkg::OpWeld) n_weld++;
      else if (op == gvwm_pkg::OpRemap) n_remap++;
      else n_clear++;
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);  // an ignored item may still be in flight
  endtask

  task automatic write_tolerance(input logic [31:0] v);
    drain();
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    inv_tol = v;
  endtask

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(32'h0003_0000) - 32'h0001_8000;  // small, many shared cells
      2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      default: return 32'h0001_0000 * $urandom_range(3);
    endcase
  endfunction

  task automatic test_directed();
    send_item(gvwm_pkg::OpRemap, 0, 0, 0, 10'd0);       // unwelded index on empty map
    send_item(gvwm_pkg::OpWeld, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
    send_item(gvwm_pkg::OpWeld, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_FFFF, 0); // same cell
    send_item(gvwm_pkg::OpWeld, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_0000, 0);
    send_item(gvwm_pkg::OpWeld, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_0000, 10'h3FF);
    send_item(gvwm_pkg::OpUnused, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'h3FF);
    send_item(gvwm_pkg::OpRemap, 0, 0, 0, 10'd1);
    send_item(gvwm_pkg::OpRemap, 0, 0, 0, 10'd3);
    send_item(gvwm_pkg::OpRemap, 0, 0, 0, 10'd4);       // just past the end
    send_item(gvwm_pkg::OpRemap, 0, 0, 0, 10'h3FF);
    send_item(gvwm_pkg::OpClear, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'h3FF);
    send_item(gvwm_pkg::OpRemap, 0, 0, 0, 10'd0);       // map gone after clear
  endtask

  task automatic test_tolerance_extremes();
    write_tolerance(32'd0);                             // every vertex in cell (0,0,0)
    send_item(gvwm_pkg::OpWeld, 32'h8000_0000, 32'h1234_5678, 32'h7FFF_FFFF, 0);
    send_item(gvwm_pkg::OpWeld, 32'h0000_0001, 32'hFFFF_FFFF, 0, 0);
    write_tolerance(32'hFFFF_FFFF);
    send_item(gvwm_pkg::OpWeld, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    send_item(gvwm_pkg::OpWeld, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    send_item(gvwm_pkg::OpWeld, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000, 0);
    write_tolerance(32'd1);
    send_item(gvwm_pkg::OpWeld, 32'hFFFF_FFFF, 0, 32'h8000_0000, 0);
    send_item(gvwm_pkg::OpRemap, 0, 0, 0, 10'd5);
    send_item(gvwm_pkg::OpClear, 0, 0, 0, 0);
  endtask

  // fill past capacity: distinct cells, then welds rejected with capacity status
  task automatic test_capacity();
    write_tolerance(32'h0001_0000);
    for (int i = 0; i < Verts + 3; i++)
      send_item(gvwm_pkg::OpWeld, i << 16, (i * 7) << 16, 32'hFFFF_0000 - (i << 16), 0);
    send_item(gvwm_pkg::OpRemap, 0, 0, 0, 10'h3FF);
    send_item(gvwm_pkg::OpRemap, 0, 0, 0, 10'd0);
    send_item(gvwm_pkg::OpClear, 0, 0, 0, 0);
  endtask

  task automatic test_random(input int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 60)
        send_item(gvwm_pkg::OpWeld, rnd_coord(), rnd_coord(), rnd_coord(), 10'($urandom()));
      else if (r < 90)
        send_item(gvwm_pkg::OpRemap, $urandom(), $urandom(), $urandom(),
                  $urandom_range(1) ? 10'($urandom_range(verts_welded + 2)) : 10'($urandom()));
      else if (r < 94)
        send_item(gvwm_pkg::OpClear, $urandom(), $urandom(), $urandom(), 10'($urandom()));
      else
        send_item(gvwm_pkg::OpUnused, $urandom(), $urandom(), $urandom(), 10'($urandom()));
    end
  endtask

  initial begin
    inv_tol = gvwm_pkg::InvTolReset;
    ids_given = 0; verts_welded = 0;
    foreach (tbl_used[i]) tbl_used[i] = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_tolerance_extremes();
    test_capacity();
    write_tolerance(32'h0000_8000);
    test_random(100);
    idle_pct_src = 46;
    write_tolerance(32'h0004_0000);
    test_random(100);
    drain();  // sender waits until every result has come back
    idle_pct_src = 0; idle_pct_snk = 46;
    test_random(100);
    idle_pct_src = 27; idle_pct_snk = 27;
    write_tolerance(32'h0000_0100);
    test_random(100);
    idle_pct_src = 0; idle_pct_snk = 0;

    drain();
    $display("covered %0d welds, %0d remaps, %0d clears; %0d results checked",
             n_weld, n_remap, n_clear, checked);
    $display("tolerance register 0, max, raw 1, 1.0, 0.5, 4.0 and 1/256; capacity overflow hit");
    if (errors == 0)
      $display("tb_grid_vertex_weld_map: done, clean");
    else
      $display("tb_grid_vertex_weld_map: done, errors");
    $finish;
  end
endmodule
`default_nettype wire
